[rtl/core/bscd_pkg.sv]
// Package for the byte string class detector: class codes, item type and byte classes.
`default_nettype none

package bscd_pkg;

  typedef enum logic [2:0] {
    CLS_EMPTY = 3'd0,
    CLS_NUM   = 3'd1,
    CLS_ALPHA = 3'd2,
    CLS_ALNUM = 3'd3,
    CLS_B64   = 3'd4,
    CLS_PRINT = 3'd5,
    CLS_READ  = 3'd6,
    CLS_BIN   = 3'd7
  } cls_t;

  localparam logic [7:0] CHAR_PAD   = 8'h3D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       has_char;
    logic       last;
  } item_t;

  function automatic logic is_dig(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_alp(input logic [7:0] c);
    return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
  endfunction

  function automatic logic is_prn(input logic [7:0] c);
    return c inside {[8'h20:8'h7E]};
  endfunction

  function automatic logic is_spc(input logic [7:0] c);
    return c inside {[8'h09:8'h0D], 8'h20};
  endfunction

  function automatic logic is_b64_special(input logic [7:0] c);
    return c inside {CHAR_PLUS, CHAR_SLASH, CHAR_PAD};
  endfunction

  function automatic cls_t fall_print(input logic [7:0] c);
    cls_t r;
    if (is_prn(c)) r = CLS_PRINT;
    else if (is_spc(c)) r = CLS_READ;
    else r = CLS_BIN;
    return r;
  endfunction

  function automatic cls_t next_class(input cls_t cls, input logic [7:0] c);
    cls_t r;
    case (cls)
      CLS_EMPTY: begin
        if (is_dig(c)) r = CLS_NUM;
        else if (is_alp(c)) r = CLS_ALPHA;
        else if (is_b64_special(c)) r = CLS_B64;
        else r = fall_print(c);
      end
      CLS_NUM: begin
        if (is_dig(c)) r = CLS_NUM;
        else if (is_alp(c)) r = CLS_ALNUM;
        else if (is_b64_special(c)) r = CLS_B64;
        else r = fall_print(c);
      end
      CLS_ALPHA: begin
        if (is_alp(c)) r = CLS_ALPHA;
        else if (is_dig(c)) r = CLS_ALNUM;
        else if (is_b64_special(c)) r = CLS_B64;
        else r = fall_print(c);
      end
      CLS_ALNUM: begin
        if (is_dig(c) || is_alp(c)) r = CLS_ALNUM;
        else if (is_b64_special(c)) r = CLS_B64;
        else r = fall_print(c);
      end
      CLS_B64: begin
        if (is_dig(c) || is_alp(c) || is_b64_special(c)) r = CLS_B64;
        else r = fall_print(c);
      end
      CLS_PRINT: begin
        if (is_prn(c)) r = CLS_PRINT;
        else if (is_spc(c)) r = CLS_READ;
        else r = CLS_BIN;
      end
      CLS_READ: begin
        if (is_prn(c) || is_spc(c)) r = CLS_READ;
        else r = CLS_BIN;
      end
      default: r = CLS_BIN;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/core/bscd_in_reg.sv]
// Input register stage that holds one accepted item until the classifier takes it.
`default_nettype none

module bscd_in_reg
  import bscd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       item_valid,
  output logic            item_stall,
  input  wire logic [7:0] char_byte,
  input  wire logic       has_char,
  input  wire logic       last,
  output logic            held_valid,
  output item_t           held,
  input  wire logic       take
);

  logic load;

  assign item_stall = held_valid && !take;
  assign load       = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (load) begin
      held_valid <= 1'b1;
    end else if (take) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held.char_byte <= char_byte;
      held.has_char  <= has_char;
      held.last      <= last;
    end
  end

endmodule

`default_nettype wire

[rtl/core/bscd_classify.sv]
// String state update, end-of-string base64 check and result register.
`default_nettype none

module bscd_classify
  import bscd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  held_valid,
  input  wire item_t held,
  output logic       take,
  output logic       class_valid,
  input  wire logic  class_stall,
  output logic [2:0] string_class
);

  cls_t       cls;
  cls_t       cls_next;
  logic [1:0] len_mod;
  logic [1:0] len_mod_next;
  logic       at_four;
  logic       at_four_next;
  logic [1:0] pad_run;
  logic [1:0] pad_run_next;
  logic       pad_bad;
  logic       pad_bad_next;
  logic       upd;
  logic       b64_ok;
  cls_t       result;

  assign take = held_valid && (!held.last || !class_valid || !class_stall);
  assign upd  = take && held.has_char && (cls != CLS_BIN);

  always_comb begin
    cls_next     = cls;
    len_mod_next = len_mod;
    at_four_next = at_four;
    pad_run_next = pad_run;
    pad_bad_next = pad_bad;
    if (upd) begin
      cls_next     = next_class(cls, held.char_byte);
      at_four_next = at_four || (len_mod == 2'd3);
      len_mod_next = len_mod + 2'd1;
      if (held.char_byte == CHAR_PAD) begin
        if (pad_run != 2'd3) pad_run_next = pad_run + 2'd1;
      end else begin
        if (pad_run != 2'd0) pad_bad_next = 1'b1;
        pad_run_next = 2'd0;
      end
    end
  end

  assign b64_ok = (len_mod_next == 2'd0) && at_four_next && !pad_bad_next &&
                  (pad_run_next != 2'd3);

  always_comb begin
    result = cls_next;
    if (cls_next == CLS_B64 && !b64_ok) result = CLS_PRINT;
  end

  always_ff @(posedge clk) begin
    if (rst || (take && held.last)) begin
      cls     <= CLS_EMPTY;
      len_mod <= 2'd0;
      at_four <= 1'b0;
      pad_run <= 2'd0;
      pad_bad <= 1'b0;
    end else begin
      cls     <= cls_next;
      len_mod <= len_mod_next;
      at_four <= at_four_next;
      pad_run <= pad_run_next;
      pad_bad <= pad_bad_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      class_valid <= 1'b0;
    end else if (take && held.last) begin
      class_valid <= 1'b1;
    end else if (!class_stall) begin
      class_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && held.last) begin
      string_class <= result;
    end
  end

endmodule

`default_nettype wire

[rtl/core/byte_string_class_detector.sv]
// Top level of the byte string class detector.
//
//   Channel  Handshake                Payload
//   item     item_valid, item_stall   char_byte[7:0], has_char, last
//   class    class_valid, class_stall string_class[2:0]
//
// Each item is registered in the input register and then folded into the string
// state; one item per cycle is sustained unless a stalled class output holds a
// last item. A class appears in the cycle after the item marked last is taken.
// Synchronous reset empties both registers and clears the string state.
// A stalled class output holds the input register only when it carries a last item.
`default_nettype none

module byte_string_class_detector
  import bscd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       item_valid,
  output logic            item_stall,
  input  wire logic [7:0] char_byte,
  input  wire logic       has_char,
  input  wire logic       last,
  output logic            class_valid,
  input  wire logic       class_stall,
  output logic [2:0]      string_class
);

  logic  held_valid;
  item_t held;
  logic  take;

  bscd_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .char_byte  (char_byte),
    .has_char   (has_char),
    .last       (last),
    .held_valid (held_valid),
    .held       (held),
    .take       (take)
  );

  bscd_classify u_classify (
    .clk          (clk),
    .rst          (rst),
    .held_valid   (held_valid),
    .held         (held),
    .take         (take),
    .class_valid  (class_valid),
    .class_stall  (class_stall),
    .string_class (string_class)
  );

endmodule

`default_nettype wire
